@@ rtl/cfp_pkg.sv @@
// shared types and constants of the framed packet parser
package cfp_pkg;

   // result status codes
   localparam logic [2:0] ST_MORE    = 3'd0;
   localparam logic [2:0] ST_READY   = 3'd1;
   localparam logic [2:0] ST_FORMAT  = 3'd2;
   localparam logic [2:0] ST_VERSION = 3'd3;
   localparam logic [2:0] ST_CRC     = 3'd4;

   // result kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_WORD   = 1'b1;

   // configuration register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_VERSION = 2'd2;
   localparam logic [7:0] PROTOCOL_VERSION_RESET = 8'd1;

   // frame layout
   localparam int HDR_SIZE    = 14;
   localparam int CRC_SIZE    = 2;
   localparam int OFS_VERSION = 2;
   localparam int OFS_TYPE    = 3;
   localparam int OFS_LENGTH  = 4;
   localparam int OFS_SEQ     = 6;
   localparam int OFS_UPTIME  = 10;

   // crc-16/ccitt-false
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // latch the accepted byte
      logic eval;       // process the byte and load the result register
      logic load_word;  // load the next payload word into the result register
   } cfp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic frame_good;  // the byte under evaluation completes a good frame
      logic has_words;   // the completed frame carries payload
      logic last_word;   // the word being loaded is the final one
   } cfp_sts_type;

endpackage

@@ rtl/cfp_if.sv @@
// byte and result channel interfaces of the framed packet parser

interface cfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        item_kind;
   logic [7:0]  msg_type;
   logic [6:0]  payload_bytes;
   logic [31:0] frame_sequence;
   logic [31:0] sender_uptime;
   logic [63:0] payload_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, output status, output item_kind, output msg_type,
                   output payload_bytes, output frame_sequence, output sender_uptime,
                   output payload_word, output word_index, output last, input ready);
   modport sink   (input valid, input status, input item_kind, input msg_type,
                   input payload_bytes, input frame_sequence, input sender_uptime,
                   input payload_word, input word_index, input last, output ready);
endinterface

@@ rtl/cfp_datapath.sv @@
// datapath of the framed packet parser: header fields, crc, payload memory, result register
module cfp_datapath #(
   parameter int MAX_PAYLOAD = 64,
   parameter int MAX_FRAME   = 80
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfp_pkg::cfp_cmd_type          cmd,
   output cfp_pkg::cfp_sts_type          sts,
   input  logic [7:0]                    rx_byte,
   input  logic                          csr_we,
   input  logic [cfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata,
   output logic [2:0]                    status,
   output logic                          item_kind,
   output logic [7:0]                    msg_type,
   output logic [6:0]                    payload_bytes,
   output logic [31:0]                   frame_sequence,
   output logic [31:0]                   sender_uptime,
   output logic [63:0]                   payload_word,
   output logic [2:0]                    word_index,
   output logic                          last
);

   localparam int SPAN  = (MAX_FRAME > MAX_PAYLOAD + cfp_pkg::HDR_SIZE + cfp_pkg::CRC_SIZE)
                          ? MAX_FRAME : MAX_PAYLOAD + cfp_pkg::HDR_SIZE + cfp_pkg::CRC_SIZE;
   localparam int CW    = $clog2(SPAN + 1);
   localparam int DEPTH = (MAX_PAYLOAD + 7) / 8;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW    = AW + 1;

   // byte crc update, one bit per step
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {d, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ((r << 1) ^ cfp_pkg::CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   // configuration registers
   logic [7:0] magic_first_ff, magic_second_ff, version_cfg_ff;

   // frame tracking
   logic [7:0]    byte_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] total_ff, total_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crc_lo_ff, crc_lo_in;

   // header fields
   logic [7:0]  ver_ff, ver_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] up_ff, up_in;

   // payload word assembly and memory
   logic [63:0]   acc_ff, acc_in;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [63:0]   mem [DEPTH];
   logic [63:0]   rd_ff;
   logic [AW-1:0] w_ff, w_in;
   logic [WW-1:0] words;

   // evaluation results
   logic [2:0] res_status;
   logic       good;

   // result register
   logic [2:0]  status_ff;
   logic        kind_ff;
   logic [7:0]  msg_type_ff;
   logic [6:0]  len_out_ff;
   logic [31:0] seq_out_ff;
   logic [31:0] up_out_ff;
   logic [63:0] word_out_ff;
   logic [2:0]  index_out_ff;
   logic        last_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= '0;
         magic_second_ff <= '0;
         version_cfg_ff  <= cfp_pkg::PROTOCOL_VERSION_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cfp_pkg::CSR_MAGIC_FIRST:      magic_first_ff  <= csr_wdata;
            cfp_pkg::CSR_MAGIC_SECOND:     magic_second_ff <= csr_wdata;
            cfp_pkg::CSR_PROTOCOL_VERSION: version_cfg_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign words = WW'((len_ff + 16'd7) >> 3);

   // byte evaluation
   always_comb begin
      logic [CW-1:0] fill_nx;
      logic [CW-1:0] tot_v;
      logic [CW-1:0] pay_off;
      logic [2:0]    lane;
      logic          err;
      fill_nx    = fill_ff + CW'(1);
      tot_v      = total_ff;
      pay_off    = fill_ff - CW'(cfp_pkg::HDR_SIZE);
      lane       = pay_off[2:0];
      err        = 1'b0;
      fill_in    = fill_ff;
      total_in   = total_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      ver_in     = ver_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      seq_in     = seq_ff;
      up_in      = up_ff;
      acc_in     = acc_ff;
      mem_we     = 1'b0;
      mem_waddr  = AW'(pay_off >> 3);
      res_status = cfp_pkg::ST_MORE;
      good       = 1'b0;
      if (cmd.eval) begin
         if (fill_ff == '0) begin
            if (byte_ff == magic_first_ff) fill_in = CW'(1);
         end else if (fill_ff == CW'(1)) begin
            if (byte_ff == magic_second_ff) begin
               fill_in = CW'(2);
            end else begin
               fill_in  = (byte_ff == magic_first_ff) ? CW'(1) : '0;
               total_in = '0;
            end
         end else if (fill_ff >= CW'(MAX_FRAME)) begin
            fill_in    = (byte_ff == magic_first_ff) ? CW'(1) : '0;
            total_in   = '0;
            res_status = cfp_pkg::ST_FORMAT;
         end else begin
            fill_in = fill_nx;
            // header field capture
            case (fill_ff)
               CW'(cfp_pkg::OFS_VERSION):    ver_in       = byte_ff;
               CW'(cfp_pkg::OFS_TYPE):       type_in      = byte_ff;
               CW'(cfp_pkg::OFS_LENGTH):     len_in[7:0]  = byte_ff;
               CW'(cfp_pkg::OFS_LENGTH + 1): len_in[15:8] = byte_ff;
               CW'(cfp_pkg::OFS_SEQ):        seq_in[7:0]   = byte_ff;
               CW'(cfp_pkg::OFS_SEQ + 1):    seq_in[15:8]  = byte_ff;
               CW'(cfp_pkg::OFS_SEQ + 2):    seq_in[23:16] = byte_ff;
               CW'(cfp_pkg::OFS_SEQ + 3):    seq_in[31:24] = byte_ff;
               CW'(cfp_pkg::OFS_UPTIME):     up_in[7:0]    = byte_ff;
               CW'(cfp_pkg::OFS_UPTIME + 1): up_in[15:8]   = byte_ff;
               CW'(cfp_pkg::OFS_UPTIME + 2): up_in[23:16]  = byte_ff;
               CW'(cfp_pkg::OFS_UPTIME + 3): up_in[31:24]  = byte_ff;
               default: ;
            endcase
            // running crc over version through payload
            if (total_ff == '0 || fill_ff < total_ff - CW'(cfp_pkg::CRC_SIZE)) begin
               crc_in = crc16_byte((fill_ff == CW'(cfp_pkg::OFS_VERSION))
                                   ? cfp_pkg::CRC_INIT : crc_ff, byte_ff);
            end
            // low crc byte
            if (total_ff != '0 && fill_ff == total_ff - CW'(cfp_pkg::CRC_SIZE)) begin
               crc_lo_in = byte_ff;
            end
            // payload bytes packed into words
            if (total_ff != '0 && fill_ff >= CW'(cfp_pkg::HDR_SIZE)
                && fill_ff < total_ff - CW'(cfp_pkg::CRC_SIZE)) begin
               acc_in = ((lane == 3'd0) ? 64'd0 : acc_ff) | (64'(byte_ff) << {lane, 3'b000});
               mem_we = (lane == 3'd7) || (fill_ff == total_ff - CW'(cfp_pkg::CRC_SIZE + 1));
            end
            // header complete: length then version
            if (fill_nx == CW'(cfp_pkg::HDR_SIZE)) begin
               if (len_ff > 16'(MAX_PAYLOAD)) begin
                  err        = 1'b1;
                  res_status = cfp_pkg::ST_FORMAT;
               end else if (ver_ff != version_cfg_ff) begin
                  err        = 1'b1;
                  res_status = cfp_pkg::ST_VERSION;
               end else begin
                  tot_v    = CW'(cfp_pkg::HDR_SIZE + cfp_pkg::CRC_SIZE) + CW'(len_ff);
                  total_in = tot_v;
               end
            end
            // frame end and crc check
            if (!err && tot_v != '0 && fill_nx >= tot_v) begin
               if ({byte_ff, crc_lo_ff} != crc_ff) begin
                  err        = 1'b1;
                  res_status = cfp_pkg::ST_CRC;
               end else begin
                  good       = 1'b1;
                  res_status = cfp_pkg::ST_READY;
                  fill_in    = '0;
                  total_in   = '0;
               end
            end
            if (err) begin
               fill_in  = (byte_ff == magic_first_ff) ? CW'(1) : '0;
               total_in = '0;
            end
         end
      end
   end

   // word counter, read address runs one step ahead of the result register
   always_comb begin
      w_in = w_ff;
      if (cmd.eval) begin
         w_in = '0;
      end else if (cmd.load_word && !sts.last_word) begin
         w_in = w_ff + AW'(1);
      end
   end

   assign sts.frame_good = good;
   assign sts.has_words  = (len_ff != 16'd0);
   assign sts.last_word  = ((WW'(w_ff) + WW'(1)) == words);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         total_ff <= '0;
         w_ff     <= '0;
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
         w_ff     <= w_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (cmd.capture) byte_ff <= rx_byte;
      crc_ff    <= crc_in;
      crc_lo_ff <= crc_lo_in;
      ver_ff    <= ver_in;
      type_ff   <= type_in;
      len_ff    <= len_in;
      seq_ff    <= seq_in;
      up_ff     <= up_in;
      acc_ff    <= acc_in;
   end

   // payload word memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= acc_in;
      rd_ff <= mem[w_in];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         status_ff    <= res_status;
         kind_ff      <= cfp_pkg::KIND_HEADER;
         msg_type_ff  <= good ? type_ff : 8'd0;
         len_out_ff   <= good ? len_ff[6:0] : 7'd0;
         seq_out_ff   <= good ? seq_ff : 32'd0;
         up_out_ff    <= good ? up_ff : 32'd0;
         word_out_ff  <= 64'd0;
         index_out_ff <= 3'd0;
         last_ff      <= !good || (len_ff == 16'd0);
      end else if (cmd.load_word) begin
         status_ff    <= cfp_pkg::ST_READY;
         kind_ff      <= cfp_pkg::KIND_WORD;
         word_out_ff  <= rd_ff;
         index_out_ff <= 3'(w_ff);
         last_ff      <= sts.last_word;
      end
   end

   assign status         = status_ff;
   assign item_kind      = kind_ff;
   assign msg_type       = msg_type_ff;
   assign payload_bytes  = len_out_ff;
   assign frame_sequence = seq_out_ff;
   assign sender_uptime  = up_out_ff;
   assign payload_word   = word_out_ff;
   assign word_index     = index_out_ff;
   assign last           = last_ff;

endmodule

@@ rtl/cfp_controller.sv @@
// controller of the framed packet parser: beat sequencing and result valid
module cfp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cfp_pkg::cfp_cmd_type cmd,
   input  cfp_pkg::cfp_sts_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WORDS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.capture   = 1'b0;
      cmd.eval      = 1'b0;
      cmd.load_word = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               cmd.eval     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = (sts.frame_good && sts.has_words) ? S_WORDS : S_IDLE;
            end
         end
         S_WORDS: begin
            if (out_free) begin
               cmd.load_word = 1'b1;
               rsp_valid_in  = 1'b1;
               if (sts.last_word) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/crc_framed_packet_parser_core.sv @@
// Byte-serial frame parser with magic sync, length field and CRC-16/CCITT-FALSE check.
//
// req_bus carries one received byte per beat; rsp_bus carries result beats. Every
// byte gives one status result, except the byte that completes a good frame, which
// gives a header result followed by ceil(length/8) payload word results.
// A byte is first captured; once the result register is free, the sequencer's
// evaluation step runs and loads the result register. A good frame's payload words
// follow at one per cycle while the receiver takes them, read from the word-wide
// payload memory; the closing byte of a frame holds the input until the last is loaded.
// The input is taken again once the last result of a byte is in the result register,
// even while that result still waits for the receiver.
// When the receiver stalls, the result register holds its beat and the sequencer
// waits; no byte and no result is lost.
// Reset (synchronous, active high) clears the configuration to magic 0/0, version 1,
// and puts the parser in the hunt for the first magic byte. The payload memory needs
// no clearing pass. csr_we writes register csr_index (0 magic_first, 1 magic_second,
// 2 protocol_version); other indexes are ignored.
module crc_framed_packet_parser_core #(
   parameter int MAX_PAYLOAD = 64,
   parameter int MAX_FRAME   = 80
) (
   input  logic                          clock,
   input  logic                          reset,
   cfp_req_if.sink                       req_bus,
   cfp_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [cfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);

   cfp_pkg::cfp_cmd_type cmd;
   cfp_pkg::cfp_sts_type sts;
   logic                 req_ready;
   logic                 rsp_valid;

   // sequencer
   cfp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // frame datapath
   cfp_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .MAX_FRAME   (MAX_FRAME)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .rx_byte        (req_bus.rx_byte),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .status         (rsp_bus.status),
      .item_kind      (rsp_bus.item_kind),
      .msg_type       (rsp_bus.msg_type),
      .payload_bytes  (rsp_bus.payload_bytes),
      .frame_sequence (rsp_bus.frame_sequence),
      .sender_uptime  (rsp_bus.sender_uptime),
      .payload_word   (rsp_bus.payload_word),
      .word_index     (rsp_bus.word_index),
      .last           (rsp_bus.last)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   // a captured byte is evaluated before the next one is taken
   a_one_byte_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("byte accepted while the previous one is still in evaluation");

   // payload words only belong to a good frame
   a_word_is_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.item_kind == cfp_pkg::KIND_WORD)
      |-> rsp_bus.status == cfp_pkg::ST_READY)
      else $error("payload word beat without ready status");

   // a plain status result is always the only result of its byte
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != cfp_pkg::ST_READY) |-> rsp_bus.last)
      else $error("status beat not marked last");

   // no new byte is taken while payload words are still being sent
   a_no_input_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == cfp_pkg::ST_READY && !rsp_bus.last
       && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken before all words of a frame were sent");

endmodule
